/* rtl/gplc_pkg.sv */
// ----------------------------------------------------------------------------
// Gripper paddle and lift controller package
// Shared types, field widths and code points for the gripper controller.
// ----------------------------------------------------------------------------
package gplc_pkg;

   // Fixed point format of positions: FRACTION_BITS fraction bits, one is full travel.
   localparam int FRACTION_BITS = 16;
   localparam int POS_W         = FRACTION_BITS + 1;
   localparam int STEP_W        = 17;
   localparam int SPAN_W        = 16;
   localparam int WIDTH_W       = 16;
   localparam int CMD_W         = 3;
   localparam int MODE_W        = 2;
   localparam int SUM_W         = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 17;

   localparam logic [POS_W-1:0] POS_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   // Command codes.
   localparam logic [CMD_W-1:0] OP_KEEP  = 3'd0;
   localparam logic [CMD_W-1:0] OP_NOOP  = 3'd1;
   localparam logic [CMD_W-1:0] OP_CLOSE = 3'd2;
   localparam logic [CMD_W-1:0] OP_OPEN  = 3'd3;
   localparam logic [CMD_W-1:0] OP_UP    = 3'd4;
   localparam logic [CMD_W-1:0] OP_DOWN  = 3'd5;

   // Paddle modes.
   localparam logic [MODE_W-1:0] PM_OPEN    = 2'd0;
   localparam logic [MODE_W-1:0] PM_CLOSED  = 2'd1;
   localparam logic [MODE_W-1:0] PM_OPENING = 2'd2;
   localparam logic [MODE_W-1:0] PM_CLOSING = 2'd3;

   // Lift modes.
   localparam logic [MODE_W-1:0] LM_DOWN     = 2'd0;
   localparam logic [MODE_W-1:0] LM_UP       = 2'd1;
   localparam logic [MODE_W-1:0] LM_RAISING  = 2'd2;
   localparam logic [MODE_W-1:0] LM_LOWERING = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_AUTOSNATCH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRIP_SPAN  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   func;
      logic               beam_inner;
      logic               beam_outer;
      logic               touch_left;
      logic               touch_right;
      logic [WIDTH_W-1:0] object_width;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0] paddle_mode_out;
      logic [MODE_W-1:0] lift_mode_out;
      logic [POS_W-1:0]  paddle_pos_out;
      logic [POS_W-1:0]  lift_pos_out;
      logic              holding_out;
      logic              grabbed_now;
      logic              released_now;
      logic              stalled;
      logic              moved;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* rtl/gplc_div.sv */
// ----------------------------------------------------------------------------
// Gripper closing limit divider
// Restoring divider that yields the fraction bits of numer / denom, numer < denom.
// ----------------------------------------------------------------------------
module gplc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [gplc_pkg::WIDTH_W-1:0]       numer,
   input  logic [gplc_pkg::SPAN_W-1:0]        denom,
   output gplc_pkg::div_stat_type             stat,
   output logic [gplc_pkg::FRACTION_BITS-1:0] quot
);
   import gplc_pkg::*;

   localparam int CNT_W = $clog2(FRACTION_BITS);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [SPAN_W-1:0]        rem_ff, rem_in;
   logic [SPAN_W-1:0]        denom_ff, denom_in;
   logic [FRACTION_BITS-1:0] quot_ff, quot_in;
   logic [SPAN_W:0]          shifted;
   logic                     fits;
   logic                     last;

   // One quotient bit per cycle; the low dividend bits are all zero.
   assign shifted = {rem_ff, 1'b0};
   assign fits    = shifted >= {1'b0, denom_ff};
   assign last    = count_ff == CNT_W'(FRACTION_BITS - 1);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = SPAN_W'(numer);
         denom_in = denom;
      end else if (busy_ff) begin
         rem_in   = fits ? SPAN_W'(shifted - {1'b0, denom_ff}) : shifted[SPAN_W-1:0];
         quot_in  = {quot_ff[FRACTION_BITS-2:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      quot_ff  <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;

endmodule

/* rtl/gripper_paddle_lift_controller_unit.sv */
// ----------------------------------------------------------------------------
// Gripper paddle and lift controller
// Command latch, paddle and lift ramp machines, grip detection and closing limit.
// ----------------------------------------------------------------------------
// Each request is one control tick and produces exactly one response. The
// command, both position ramps, the release check and the grip check are
// evaluated in the accept cycle and the response is registered at its edge, so
// ticks without a grip are taken back to back as long as the response register
// drains. A tick that grips an object whose width is below the grip span
// computes the new closing limit, one minus width over span, with a restoring
// divider that produces one quotient bit per cycle; the block then takes no new
// request until that divider loop is done and its result is stored. The response
// of such a tick is offered right away, since the limit does not appear in it.
// Objects at least as wide as the span, or a zero span, give a closing limit of
// zero without a divide. Positions are unsigned fixed point where 65536 is full
// travel. Register writes are taken at any time but are meant to be made only
// while the block is idle.
module gripper_paddle_lift_controller_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  gplc_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output gplc_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gplc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gplc_pkg::CSR_DATA_W-1:0]       csr_data
);
   import gplc_pkg::*;

   // Configuration registers.
   logic               autosnatch_ff;
   logic [STEP_W-1:0]  move_step_ff;
   logic [SPAN_W-1:0]  grip_span_ff;

   // Controller state.
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [MODE_W-1:0]  pmode_ff, pmode_in;
   logic [MODE_W-1:0]  lmode_ff, lmode_in;
   logic [POS_W-1:0]   ppos_ff, ppos_in;
   logic [POS_W-1:0]   lpos_ff, lpos_in;
   logic [POS_W-1:0]   limit_ff, limit_in;
   logic               holding_ff, holding_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic [CMD_W-1:0]   cmd_sel;
   logic [MODE_W-1:0]  pm_cmd, lm_cmd;
   logic [SUM_W-1:0]   step_ext, pp_ext, lp_ext, pp_sum, lp_sum;
   logic               released, grabbed, stall, div_start;

   div_stat_type              div_stat;
   logic [FRACTION_BITS-1:0] div_quot;

   // The next tick needs the closing limit, so requests wait out the divider.
   assign accept    = req_valid && req_ready;
   assign req_ready = !div_stat.busy && !div_stat.done && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   always_comb begin
      cmd_sel  = cmd_ff;
      pm_cmd   = pmode_ff;
      lm_cmd   = lmode_ff;
      step_ext = SUM_W'(move_step_ff);
      pp_ext   = SUM_W'(ppos_ff);
      lp_ext   = SUM_W'(lpos_ff);
      pp_sum   = pp_ext + step_ext;
      lp_sum   = lp_ext + step_ext;
      pmode_in = pmode_ff;
      lmode_in = lmode_ff;
      ppos_in  = ppos_ff;
      lpos_in  = lpos_ff;
      limit_in = limit_ff;
      released = 1'b0;

      // A command in range replaces the stored one and stays in force.
      if (req_data.func >= OP_NOOP && req_data.func <= OP_DOWN) begin
         cmd_sel = req_data.func;
      end

      case (cmd_sel)
         OP_CLOSE: if (pmode_ff != PM_CLOSED) pm_cmd = PM_CLOSING;
         OP_OPEN:  if (pmode_ff != PM_OPEN)   pm_cmd = PM_OPENING;
         OP_UP:    if (lmode_ff != LM_UP)     lm_cmd = LM_RAISING;
         OP_DOWN:  if (lmode_ff != LM_DOWN)   lm_cmd = LM_LOWERING;
         default: ;
      endcase

      // Paddle ramp. Landing exactly on zero keeps the opening mode for a tick.
      pmode_in = pm_cmd;
      if (pm_cmd == PM_OPENING) begin
         if (pp_ext < step_ext) begin
            ppos_in  = '0;
            pmode_in = PM_OPEN;
         end else begin
            ppos_in = POS_W'(pp_ext - step_ext);
         end
         if (holding_ff && (ppos_in == '0 || ppos_in < limit_ff)) begin
            released = 1'b1;
            limit_in = POS_ONE;
         end
      end else if (pm_cmd == PM_CLOSING) begin
         if (pp_sum > SUM_W'(limit_ff)) begin
            ppos_in  = limit_ff;
            pmode_in = PM_CLOSED;
         end else begin
            ppos_in = POS_W'(pp_sum);
         end
      end

      // Lift ramp between zero and full travel.
      lmode_in = lm_cmd;
      if (lm_cmd == LM_LOWERING) begin
         if (lp_ext < step_ext) begin
            lpos_in  = '0;
            lmode_in = LM_DOWN;
         end else begin
            lpos_in = POS_W'(lp_ext - step_ext);
         end
      end else if (lm_cmd == LM_RAISING) begin
         if (lp_sum > SUM_W'(POS_ONE)) begin
            lpos_in  = POS_ONE;
            lmode_in = LM_UP;
         end else begin
            lpos_in = POS_W'(lp_sum);
         end
      end

      // Autosnatch overrides the stored command from the break beams.
      cmd_in = cmd_sel;
      if (autosnatch_ff) begin
         cmd_in = (req_data.beam_inner || req_data.beam_outer) ? OP_CLOSE : OP_OPEN;
      end

      // Grip: contact while still closing with nothing held.
      stall      = req_data.touch_left || req_data.touch_right;
      grabbed    = stall && (pmode_in == PM_CLOSING) && !(holding_ff && !released);
      holding_in = grabbed || (holding_ff && !released);
      div_start  = 1'b0;
      if (grabbed) begin
         if (grip_span_ff == '0 || req_data.object_width >= grip_span_ff) begin
            limit_in = '0;
         end else begin
            div_start = accept;
         end
      end

      rsp_in.paddle_mode_out = pmode_in;
      rsp_in.lift_mode_out   = lmode_in;
      rsp_in.paddle_pos_out  = ppos_in;
      rsp_in.lift_pos_out    = lpos_in;
      rsp_in.holding_out     = holding_in;
      rsp_in.grabbed_now     = grabbed;
      rsp_in.released_now    = released;
      rsp_in.stalled         = stall;
      rsp_in.moved           = (ppos_in != ppos_ff) || (lpos_in != lpos_ff);

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   gplc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (req_data.object_width),
      .denom (grip_span_ff),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         autosnatch_ff <= 1'b0;
         move_step_ff  <= STEP_W'(3277);
         grip_span_ff  <= SPAN_W'(250);
         cmd_ff        <= OP_NOOP;
         pmode_ff      <= PM_OPEN;
         lmode_ff      <= LM_DOWN;
         ppos_ff       <= '0;
         lpos_ff       <= '0;
         limit_ff      <= POS_ONE;
         holding_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_AUTOSNATCH: autosnatch_ff <= csr_data[0];
               CSR_MOVE_STEP:  move_step_ff  <= STEP_W'(csr_data);
               CSR_GRIP_SPAN:  grip_span_ff  <= SPAN_W'(csr_data);
               default: ;
            endcase
         end
         if (accept) begin
            cmd_ff     <= cmd_in;
            pmode_ff   <= pmode_in;
            lmode_ff   <= lmode_in;
            ppos_ff    <= ppos_in;
            lpos_ff    <= lpos_in;
            limit_ff   <= limit_in;
            holding_ff <= holding_in;
         end else if (div_stat.done) begin
            // Closing limit is one minus the fraction width / span.
            limit_ff <= POS_ONE - POS_W'(div_quot);
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_div_runs_after_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_stat.busy)
      else $error("divider did not start after a grip");

   a_div_only_when_holding: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> holding_ff)
      else $error("closing limit computed while nothing is held");

   a_closed_at_limit: assert property (@(posedge clock) disable iff (reset)
      (pmode_ff == PM_CLOSED) |-> (ppos_ff == limit_ff || div_stat.busy || div_stat.done))
      else $error("closed paddles are not at the closing limit");

   a_open_at_zero: assert property (@(posedge clock) disable iff (reset)
      (pmode_ff == PM_OPEN) |-> (ppos_ff == '0))
      else $error("open paddles are not at zero");

   a_lift_in_range: assert property (@(posedge clock) disable iff (reset)
      lpos_ff <= POS_ONE)
      else $error("lift position beyond full travel");
`endif

endmodule

/* tb/gripper_paddle_lift_controller_unit_tb.sv */
// ----------------------------------------------------------------------------
// Gripper paddle and lift controller testbench
// A directed table, then random control ticks under several register settings.
// Every response is compared field by field with a cycle-free model of the
// paddle and lift machines, or with the result carried by a typed row. Both
// handshake sides idle at random; long response hold-offs back the block up.
// ----------------------------------------------------------------------------
module gripper_paddle_lift_controller_unit_tb;
   import gplc_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int RESET_CYCLES    = 4;
   localparam int FULL_TRAVEL     = 1 << FRACTION_BITS;
   // The divider keeps the block busy after a grip, and that busy time produces
   // no response, so idle waits cover it with margin.
   localparam int SETTLE_CYCLES   = FRACTION_BITS + 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PHASES   = 8;
   localparam int TICKS_PER_PHASE = 116;
   localparam int TIMEOUT_CYCLES  = 1000000;

   // Function codes that the controller must treat like "keep".
   localparam logic [CMD_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] FUNC_SPARE_7 = 3'd7;

   // Register values used by name in the directed part.
   localparam logic [CSR_DATA_W-1:0] STEP_DEFAULT   = 17'd3277;   // 0.05 of travel
   localparam logic [CSR_DATA_W-1:0] STEP_FULL      = 17'd65536;  // full travel
   localparam logic [CSR_DATA_W-1:0] STEP_FIELD_MAX = 17'h1FFFF;
   localparam logic [CSR_DATA_W-1:0] SPAN_FIELD_MAX = 17'd65535;

   // One line of the directed table: either a register write or one request.
   // Typed rows carry their own expected response; the rest use the model.
   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      logic                  is_typed;
      req_type               tick;
      rsp_type               typed_result;
   } directed_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // Model copy of the configuration registers, at their reset values.
   logic cfg_autosnatch = 1'b0;
   int   cfg_step       = 3277;
   int   cfg_span       = 250;

   // Model copy of the controller state, at its reset values.
   logic [CMD_W-1:0]  held_cmd      = OP_NOOP;
   logic [MODE_W-1:0] paddle_phase  = PM_OPEN;
   logic [MODE_W-1:0] lift_state    = LM_DOWN;
   int                paddle_at     = 0;
   int                lift_at       = 0;
   int                closing_limit = FULL_TRAVEL;
   logic              gripping      = 1'b0;

   rsp_type          expected_ticks[$];
   directed_row_type directed_rows[$];
   int          mismatch_count    = 0;
   int          responses_checked = 0;
   // The request side asks for a long response hold-off by bumping the first
   // counter; the response side serves it and bumps the second.
   int          hold_offs_asked   = 0;
   int          hold_offs_done    = 0;

   gripper_paddle_lift_controller_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("FAILURE");
      $finish;
   end

   // Advances the model by one control tick and returns the response it owes.
   // The order matters: command latch, ramps with the release check, then the
   // autosnatch rewrite, and the grip check last.
   function automatic rsp_type compute_tick(req_type t);
      rsp_type o;
      int      old_paddle;
      int      old_lift;
      logic    grabbed;
      logic    dropped;
      logic    touched;
      longint  quotient;
      old_paddle = paddle_at;
      old_lift   = lift_at;
      grabbed    = 1'b0;
      dropped    = 1'b0;

      if (t.func >= OP_NOOP && t.func <= OP_DOWN) held_cmd = t.func;
      case (held_cmd)
         OP_CLOSE: if (paddle_phase != PM_CLOSED) paddle_phase = PM_CLOSING;
         OP_OPEN:  if (paddle_phase != PM_OPEN) paddle_phase = PM_OPENING;
         OP_UP:    if (lift_state != LM_UP) lift_state = LM_RAISING;
         OP_DOWN:  if (lift_state != LM_DOWN) lift_state = LM_LOWERING;
         default:   ;
      endcase

      if (paddle_phase == PM_OPENING) begin
         paddle_at = paddle_at - cfg_step;
         if (paddle_at < 0) begin
            paddle_at    = 0;
            paddle_phase = PM_OPEN;
         end
         // A held object slips out once the paddles back off past the limit.
         if (gripping && (paddle_at == 0 || paddle_at < closing_limit)) begin
            gripping      = 1'b0;
            dropped       = 1'b1;
            closing_limit = FULL_TRAVEL;
         end
      end else if (paddle_phase == PM_CLOSING) begin
         paddle_at = paddle_at + cfg_step;
         if (paddle_at > closing_limit) begin
            paddle_at    = closing_limit;
            paddle_phase = PM_CLOSED;
         end
      end

      if (lift_state == LM_LOWERING) begin
         lift_at = lift_at - cfg_step;
         if (lift_at < 0) begin
            lift_at    = 0;
            lift_state = LM_DOWN;
         end
      end else if (lift_state == LM_RAISING) begin
         lift_at = lift_at + cfg_step;
         if (lift_at > FULL_TRAVEL) begin
            lift_at    = FULL_TRAVEL;
            lift_state = LM_UP;
         end
      end

      if (cfg_autosnatch) held_cmd = (t.beam_inner || t.beam_outer) ? OP_CLOSE : OP_OPEN;

      touched = t.touch_left || t.touch_right;
      if (touched && paddle_phase == PM_CLOSING && !gripping) begin
         gripping = 1'b1;
         grabbed  = 1'b1;
         // The paddles may close only as far as the object allows.
         if (cfg_span == 0) begin
            closing_limit = 0;
         end else begin
            quotient      = (longint'(t.object_width) << FRACTION_BITS) / cfg_span;
            closing_limit = (quotient >= FULL_TRAVEL) ? 0 : FULL_TRAVEL - int'(quotient);
         end
      end

      o.paddle_mode_out = paddle_phase;
      o.lift_mode_out   = lift_state;
      o.paddle_pos_out  = paddle_at[POS_W-1:0];
      o.lift_pos_out    = lift_at[POS_W-1:0];
      o.holding_out     = gripping;
      o.grabbed_now     = grabbed;
      o.released_now    = dropped;
      o.stalled         = touched;
      o.moved           = (paddle_at != old_paddle) || (lift_at != old_lift);
      return o;
   endfunction

   function automatic req_type mk_req(logic [CMD_W-1:0] f, logic bi, logic bo,
                                      logic tl, logic tr, logic [WIDTH_W-1:0] w);
      req_type t;
      t.func         = f;
      t.beam_inner   = bi;
      t.beam_outer   = bo;
      t.touch_left   = tl;
      t.touch_right  = tr;
      t.object_width = w;
      return t;
   endfunction

   function automatic rsp_type mk_rsp(logic [MODE_W-1:0] pm, logic [MODE_W-1:0] lm,
                                      logic [POS_W-1:0] pp, logic stall, logic move);
      rsp_type o;
      o                = '0;
      o.paddle_mode_out = pm;
      o.lift_mode_out   = lm;
      o.paddle_pos_out  = pp;
      o.stalled         = stall;
      o.moved           = move;
      return o;
   endfunction

   task automatic add_tick(req_type t);
      directed_row_type row;
      row      = '0;
      row.tick = t;
      directed_rows.push_back(row);
   endtask

   task automatic add_typed_tick(req_type t, rsp_type w);
      directed_row_type row;
      row              = '0;
      row.tick         = t;
      row.is_typed     = 1'b1;
      row.typed_result = w;
      directed_rows.push_back(row);
   endtask

   task automatic add_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      directed_row_type row;
      row           = '0;
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_value = val;
      directed_rows.push_back(row);
   endtask

   // Idle lengths shared by both sides: mostly none, often short, sometimes long
   // enough to span the whole divider run after a grip.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random commands with sensor noise. Widths mostly stay within the span so
   // that most grips compute a real limit, and sometimes take any 16-bit value.
   function automatic req_type random_tick();
      req_type t;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      t.func = OP_KEEP;
      else if (pick < 46) t.func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      else                t.func = OP_NOOP + CMD_W'($urandom_range(0, 4));
      t.beam_inner  = ($urandom_range(0, 3) == 0);
      t.beam_outer  = ($urandom_range(0, 3) == 0);
      t.touch_left  = ($urandom_range(0, 5) == 0);
      t.touch_right = ($urandom_range(0, 5) == 0);
      if (cfg_span != 0 && $urandom_range(0, 4) != 0)
         t.object_width = WIDTH_W'($urandom_range(0, cfg_span));
      else
         t.object_width = WIDTH_W'($urandom());
      return t;
   endfunction

   task automatic flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("response %0d %s: got %0d, wanted %0d",
                                 responses_checked, name, got, want));
   endtask

   // Offers one request after an optional idle gap and predicts its response at
   // the edge where it is taken. Valid stays high when the next request follows
   // with no gap, so the handshake never drops in between.
   task automatic send_tick(req_type t, int gap, logic use_typed, rsp_type typed_result);
      rsp_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = compute_tick(t);
      expected_ticks.push_back(use_typed ? typed_result : predicted);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_AUTOSNATCH: cfg_autosnatch = val[0];
         CSR_MOVE_STEP:  cfg_step       = int'(val[STEP_W-1:0]);
         CSR_GRIP_SPAN:  cfg_span       = int'(val[SPAN_W-1:0]);
         default:        ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering requests, waits for every outstanding response, then lets
   // a possible divider run finish before anything else touches the block.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response checker. Inputs are driven with nonblocking assignments, so the
   // values read here are the ones the block saw at this same edge.
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ticks.size() == 0) begin
            flag_mismatch($sformatf("response %0d arrived with no request outstanding",
                                    responses_checked));
         end else begin
            want = expected_ticks.pop_front();
            compare_field("paddle_mode_out", 32'(rsp_data.paddle_mode_out),
                          32'(want.paddle_mode_out));
            compare_field("lift_mode_out", 32'(rsp_data.lift_mode_out),
                          32'(want.lift_mode_out));
            compare_field("paddle_pos_out", 32'(rsp_data.paddle_pos_out),
                          32'(want.paddle_pos_out));
            compare_field("lift_pos_out", 32'(rsp_data.lift_pos_out),
                          32'(want.lift_pos_out));
            compare_field("holding_out", 32'(rsp_data.holding_out),
                          32'(want.holding_out));
            compare_field("grabbed_now", 32'(rsp_data.grabbed_now),
                          32'(want.grabbed_now));
            compare_field("released_now", 32'(rsp_data.released_now),
                          32'(want.released_now));
            compare_field("stalled", 32'(rsp_data.stalled), 32'(want.stalled));
            compare_field("moved", 32'(rsp_data.moved), 32'(want.moved));
         end
         responses_checked++;
      end
   end

   // Response side: runs of ready mixed with random gaps, an occasional long
   // run with no gaps at all, and a long hold-off whenever the request side
   // asks for one. During a hold-off the block's response register fills and
   // its request ready must drop.
   initial begin : response_sink
      int run;
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_offs_asked > hold_offs_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_offs_done++;
         end
         run = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = idle_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      directed_row_type row;
      int          gap;
      int          quiet_left;
      logic [CSR_DATA_W-1:0] step_pick;
      logic [CSR_DATA_W-1:0] span_pick;
      quiet_left = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table, starting from reset values: step 0.05 of travel, span 250.
      // A keep request right after reset leaves everything at rest.
      add_typed_tick(mk_req(OP_KEEP, 0, 0, 0, 0, 16'd0),
                     mk_rsp(PM_OPEN, LM_DOWN, '0, 1'b0, 1'b0));
      // Spare function codes act like keep; contact on open paddles only stalls.
      add_typed_tick(mk_req(FUNC_SPARE_7, 1, 1, 1, 1, 16'hFFFF),
                     mk_rsp(PM_OPEN, LM_DOWN, '0, 1'b1, 1'b0));
      add_typed_tick(mk_req(FUNC_SPARE_6, 0, 0, 0, 0, 16'd0),
                     mk_rsp(PM_OPEN, LM_DOWN, '0, 1'b0, 1'b0));
      add_typed_tick(mk_req(OP_CLOSE, 0, 0, 0, 0, 16'd0),
                     mk_rsp(PM_CLOSING, LM_DOWN, STEP_DEFAULT, 1'b0, 1'b1));
      // A grip on an object wider than the span sets a zero limit, so the next
      // ramp snaps the paddles back to zero, and opening then drops the object.
      add_tick(mk_req(OP_KEEP, 0, 0, 0, 1, 16'hFFFF));
      add_tick(mk_req(OP_KEEP, 0, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_OPEN, 0, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_UP, 1, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_NOOP, 0, 1, 1, 0, 16'd7));
      // Full travel per tick: the lift saturates up, then lands exactly on zero
      // and stays lowering for one more tick.
      add_write(CSR_MOVE_STEP, STEP_FULL);
      add_tick(mk_req(OP_KEEP, 0, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_DOWN, 0, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_KEEP, 0, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_CLOSE, 0, 0, 1, 0, 16'd1));
      add_tick(mk_req(OP_KEEP, 0, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_OPEN, 0, 0, 0, 0, 16'd0));
      // A zero span gives a zero limit without any divide.
      add_write(CSR_GRIP_SPAN, '0);
      add_tick(mk_req(OP_CLOSE, 0, 0, 1, 0, 16'd5));
      add_tick(mk_req(OP_OPEN, 0, 0, 0, 0, 16'd0));
      // Widest span: a width just below it leaves a tiny limit.
      add_write(CSR_GRIP_SPAN, SPAN_FIELD_MAX);
      add_tick(mk_req(OP_KEEP, 0, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_CLOSE, 0, 0, 0, 1, 16'd65534));
      add_tick(mk_req(OP_KEEP, 0, 0, 0, 0, 16'd0));
      // A zero step freezes positions while modes still change.
      add_write(CSR_MOVE_STEP, '0);
      add_tick(mk_req(OP_OPEN, 0, 0, 0, 0, 16'd0));
      // Largest step the field holds, with the beams driving the command.
      add_write(CSR_MOVE_STEP, STEP_FIELD_MAX);
      add_write(CSR_AUTOSNATCH, 17'd1);
      add_tick(mk_req(OP_KEEP, 1, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_KEEP, 0, 0, 0, 0, 16'd0));
      add_tick(mk_req(OP_KEEP, 0, 0, 1, 0, 16'hFFFF));
      add_tick(mk_req(OP_CLOSE, 0, 1, 1, 1, 16'hFFFF));

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_write) begin
            drain();
            write_reg(row.reg_index, row.reg_value);
         end else begin
            send_tick(row.tick, idle_gap(), row.is_typed, row.typed_result);
         end
      end

      // Random phases. The first two pin the register extremes; the rest pick
      // mostly mid-range steps and spans so the machines hit their ends often.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         if (phase == 0) begin
            write_reg(CSR_AUTOSNATCH, 17'd0);
            write_reg(CSR_MOVE_STEP, 17'd1);
            write_reg(CSR_GRIP_SPAN, 17'd1);
         end else if (phase == 1) begin
            write_reg(CSR_AUTOSNATCH, 17'd1);
            write_reg(CSR_MOVE_STEP, STEP_FIELD_MAX);
            write_reg(CSR_GRIP_SPAN, SPAN_FIELD_MAX);
         end else begin
            case ($urandom_range(0, 9))
               0:       step_pick = '0;
               1:       step_pick = STEP_FULL;
               2:       step_pick = STEP_FIELD_MAX;
               default: step_pick = CSR_DATA_W'($urandom_range(800, 16000));
            endcase
            case ($urandom_range(0, 9))
               0:       span_pick = '0;
               1:       span_pick = SPAN_FIELD_MAX;
               default: span_pick = CSR_DATA_W'($urandom_range(20, 1000));
            endcase
            write_reg(CSR_AUTOSNATCH, CSR_DATA_W'($urandom_range(0, 1)));
            write_reg(CSR_MOVE_STEP, step_pick);
            write_reg(CSR_GRIP_SPAN, span_pick);
         end

         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (n == TICKS_PER_PHASE / 2 && (phase == 2 || phase == 5)) hold_offs_asked++;
            // Keep requests coming back to back while the response side is held
            // off, and now and then for a quiet stretch with no idling at all.
            if (hold_offs_asked > hold_offs_done) begin
               gap = 0;
            end else if (quiet_left > 0) begin
               gap = 0;
               quiet_left--;
            end else begin
               if ($urandom_range(0, 11) == 0) quiet_left = 30;
               gap = idle_gap();
            end
            send_tick(random_tick(), gap, 1'b0, '0);
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
